@@ rtl/core/dpw_pkg.sv @@
// dpw_pkg: shared types and constants of the depth pixel to world point unit
// payload structs, configuration layout, reset values and pipeline latency
// no dependencies
`default_nettype none

package dpw_pkg;

  localparam int COL_W   = 12;
  localparam int DEP_W   = 16;
  localparam int CLR_W   = 8;
  localparam int OUT_W   = 24;
  localparam int FRAC_W  = 24;
  localparam int ROT_W   = 18;
  localparam int TRN_W   = 21;
  localparam int CAM_W   = 46;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 63;

  localparam int LATENCY = 10;

  localparam logic [IDX_W-1:0] REG_PRINCIPAL   = 4'd0;
  localparam logic [IDX_W-1:0] REG_INV_FX      = 4'd1;
  localparam logic [IDX_W-1:0] REG_INV_FY      = 4'd2;
  localparam logic [IDX_W-1:0] REG_INV_DEPTH   = 4'd3;
  localparam logic [IDX_W-1:0] REG_ROT_0       = 4'd4;
  localparam logic [IDX_W-1:0] REG_ROT_1       = 4'd5;
  localparam logic [IDX_W-1:0] REG_ROT_2       = 4'd6;
  localparam logic [IDX_W-1:0] REG_TRANSLATION = 4'd7;

  localparam logic [31:0] RST_PRINCIPAL   = 32'd265819224;
  localparam logic [23:0] RST_INV_FX      = 24'd32388;
  localparam logic [23:0] RST_INV_FY      = 24'd32326;
  localparam logic [23:0] RST_INV_DEPTH   = 24'd16777;
  localparam logic [53:0] RST_ROT_0       = 54'd65536;
  localparam logic [53:0] RST_ROT_1       = 54'd17179869184;
  localparam logic [53:0] RST_ROT_2       = 54'd4503599627370496;
  localparam logic [62:0] RST_TRANSLATION = 63'd0;

  localparam logic signed [47:0] SAT_MAX = 48'sd8388607;
  localparam logic signed [47:0] SAT_MIN = -48'sd8388608;

  typedef struct packed {
    logic [COL_W-1:0] pixel_col;
    logic [COL_W-1:0] pixel_row;
    logic [DEP_W-1:0] depth_raw;
    logic [CLR_W-1:0] blue;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] world_x;
    logic signed [OUT_W-1:0] world_y;
    logic signed [OUT_W-1:0] world_z;
    logic [CLR_W-1:0]        out_blue;
    logic [CLR_W-1:0]        out_green;
    logic [CLR_W-1:0]        out_red;
  } point_t;

  typedef struct packed {
    logic [CLR_W-1:0] blue;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [15:0]       cx;
    logic [15:0]       cy;
    logic [FRAC_W-1:0] ifx;
    logic [FRAC_W-1:0] ify;
    logic [FRAC_W-1:0] ids;
  } intr_t;

  typedef struct packed {
    logic [2:0][2:0][ROT_W-1:0] r;
    logic [2:0][TRN_W-1:0]      t;
  } pose_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0][CAM_W-1:0]  p;
    rgb_t                   color;
  } cam_t;

endpackage

`default_nettype wire

@@ rtl/core/dpw_backproject.sv @@
// dpw_backproject: pinhole back-projection of a pixel into camera space
// five register stages, split multiply for x*z and y*z; uses dpw_pkg
`default_nettype none

module dpw_backproject (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire dpw_pkg::pixel_t pix,
  input  wire dpw_pkg::intr_t intr,
  output dpw_pkg::cam_t       cam
);

  logic                v1, v2, v3, v4, v5;
  dpw_pkg::rgb_t       c1, c2, c3, c4, c5;
  logic signed [16:0]  du1, dv1;
  logic [39:0]         zp1;
  logic [32:0]         z2, z3, z4;
  logic signed [41:0]  axp2, ayp2;
  logic signed [29:0]  ax3, ay3;
  logic signed [47:0]  pxl4, pyl4;
  logic signed [46:0]  pxh4, pyh4;
  logic signed [65:0]  sx, sy;
  logic signed [dpw_pkg::CAM_W-1:0] x5, y5;
  logic [dpw_pkg::CAM_W-1:0]        z5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    sx = ($signed(66'(pxh4)) <<< 17) + $signed(66'(pxl4)) + 66'sd32768;
    sy = ($signed(66'(pyh4)) <<< 17) + $signed(66'(pyl4)) + 66'sd32768;
  end

  always_ff @(posedge clk) begin
    c1   <= {pix.blue, pix.green, pix.red};
    du1  <= $signed({1'b0, pix.pixel_col, 4'b0000}) - $signed({1'b0, intr.cx});
    dv1  <= $signed({1'b0, pix.pixel_row, 4'b0000}) - $signed({1'b0, intr.cy});
    zp1  <= pix.depth_raw * intr.ids;

    c2   <= c1;
    z2   <= 33'((41'(zp1) + 41'd128) >> 8);
    axp2 <= du1 * $signed({1'b0, intr.ifx});
    ayp2 <= dv1 * $signed({1'b0, intr.ify});

    c3   <= c2;
    z3   <= z2;
    ax3  <= 30'((axp2 + 42'sd2048) >>> 12);
    ay3  <= 30'((ayp2 + 42'sd2048) >>> 12);

    c4   <= c3;
    z4   <= z3;
    pxl4 <= ax3 * $signed({1'b0, z3[16:0]});
    pxh4 <= ax3 * $signed({1'b0, z3[32:17]});
    pyl4 <= ay3 * $signed({1'b0, z3[16:0]});
    pyh4 <= ay3 * $signed({1'b0, z3[32:17]});

    c5   <= c4;
    x5   <= dpw_pkg::CAM_W'(sx >>> 16);
    y5   <= dpw_pkg::CAM_W'(sy >>> 16);
    z5   <= dpw_pkg::CAM_W'(z4);
  end

  always_comb begin
    cam.valid = v5;
    cam.p[0]  = x5;
    cam.p[1]  = y5;
    cam.p[2]  = z5;
    cam.color = c5;
  end

endmodule

`default_nettype wire

@@ rtl/core/dpw_transform.sv @@
// dpw_transform: rigid transform of a camera point, rounding and saturation
// four register stages of split multiplies, row sums, rounding, clamp; uses dpw_pkg
`default_nettype none

module dpw_transform (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dpw_pkg::cam_t  cam,
  input  wire dpw_pkg::pose_t pose,
  output logic                out_valid,
  output dpw_pkg::point_t     point
);

  logic               v6, v7, v8, v9;
  dpw_pkg::rgb_t      c6, c7, c8, c9;
  logic signed [41:0] pl6 [3][3];
  logic signed [40:0] ph6 [3][3];
  logic signed [45:0] lo7 [3];
  logic signed [42:0] hi7 [3];
  logic signed [67:0] w   [3];
  logic signed [47:0] r8  [3];
  logic signed [dpw_pkg::OUT_W-1:0] o9 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v6 <= cam.valid;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = ($signed(68'(hi7[i])) <<< 23) + $signed(68'(lo7[i])) + 68'sd524288;
    end
  end

  always_ff @(posedge clk) begin
    c6 <= cam.color;
    c7 <= c6;
    c8 <= c7;
    c9 <= c8;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pl6[i][j] <= $signed(pose.r[i][j]) * $signed({1'b0, cam.p[j][22:0]});
        ph6[i][j] <= $signed(pose.r[i][j]) * $signed(cam.p[j][45:23]);
      end
      lo7[i] <= pl6[i][0] + pl6[i][1] + pl6[i][2] + ($signed(pose.t[i]) <<< 22);
      hi7[i] <= ph6[i][0] + ph6[i][1] + ph6[i][2];
      r8[i]  <= 48'(w[i] >>> 20);
      if (r8[i] > dpw_pkg::SAT_MAX) begin
        o9[i] <= dpw_pkg::OUT_W'(dpw_pkg::SAT_MAX);
      end else if (r8[i] < dpw_pkg::SAT_MIN) begin
        o9[i] <= dpw_pkg::OUT_W'(dpw_pkg::SAT_MIN);
      end else begin
        o9[i] <= dpw_pkg::OUT_W'(r8[i]);
      end
    end
  end

  always_comb begin
    out_valid       = v9;
    point.world_x   = o9[0];
    point.world_y   = o9[1];
    point.world_z   = o9[2];
    point.out_blue  = c9.blue;
    point.out_green = c9.green;
    point.out_red   = c9.red;
  end

endmodule

`default_nettype wire

@@ rtl/core/depth_pixel_to_world_point_unit.sv @@
// depth_pixel_to_world_point_unit: top level, configuration registers and input stage
// instantiates dpw_backproject and dpw_transform; uses dpw_pkg
`default_nettype none

// Takes one pixel request per clock and never stalls: busy stays low. A request
// with nonzero depth gives one world point, with its color, on result while done
// is high for one cycle; a request with zero depth gives nothing. The ten-stage
// pipeline takes its length from the multiplies, split into partial products, in
// the back-projection and in the rotation. The receiver cannot hold results off.
// The user must write pose and intrinsics through wr_en, wr_index and wr_data
// only while no request is in flight; the block itself does not enforce this.

module depth_pixel_to_world_point_unit #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire dpw_pkg::pixel_t               request,
  input  wire logic                          wr_en,
  input  wire logic [dpw_pkg::IDX_W-1:0]     wr_index,
  input  wire logic [dpw_pkg::DATA_W-1:0]    wr_data,
  output logic                               done,
  output dpw_pkg::point_t                    result
);

  localparam int COORD_KEEP = (COORD_BITS < dpw_pkg::COL_W) ? COORD_BITS : dpw_pkg::COL_W;
  localparam int DEPTH_KEEP = (DEPTH_BITS < dpw_pkg::DEP_W) ? DEPTH_BITS : dpw_pkg::DEP_W;
  localparam logic [dpw_pkg::COL_W-1:0] COORD_MASK =
    dpw_pkg::COL_W'((64'd1 << COORD_KEEP) - 64'd1);
  localparam logic [dpw_pkg::DEP_W-1:0] DEPTH_MASK =
    dpw_pkg::DEP_W'((64'd1 << DEPTH_KEEP) - 64'd1);

  logic [31:0]      principal;
  logic [23:0]      inv_fx, inv_fy, inv_depth;
  logic [2:0][53:0] rot_row;
  logic [62:0]      translation;

  dpw_pkg::intr_t   intr;
  dpw_pkg::pose_t   pose;
  dpw_pkg::pixel_t  pix_m;
  dpw_pkg::pixel_t  s0_pix;
  logic             s0_valid;
  dpw_pkg::cam_t    cam;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      principal   <= dpw_pkg::RST_PRINCIPAL;
      inv_fx      <= dpw_pkg::RST_INV_FX;
      inv_fy      <= dpw_pkg::RST_INV_FY;
      inv_depth   <= dpw_pkg::RST_INV_DEPTH;
      rot_row[0]  <= dpw_pkg::RST_ROT_0;
      rot_row[1]  <= dpw_pkg::RST_ROT_1;
      rot_row[2]  <= dpw_pkg::RST_ROT_2;
      translation <= dpw_pkg::RST_TRANSLATION;
    end else if (wr_en) begin
      case (wr_index)
        dpw_pkg::REG_PRINCIPAL:   principal   <= wr_data[31:0];
        dpw_pkg::REG_INV_FX:      inv_fx      <= wr_data[23:0];
        dpw_pkg::REG_INV_FY:      inv_fy      <= wr_data[23:0];
        dpw_pkg::REG_INV_DEPTH:   inv_depth   <= wr_data[23:0];
        dpw_pkg::REG_ROT_0:       rot_row[0]  <= wr_data[53:0];
        dpw_pkg::REG_ROT_1:       rot_row[1]  <= wr_data[53:0];
        dpw_pkg::REG_ROT_2:       rot_row[2]  <= wr_data[53:0];
        dpw_pkg::REG_TRANSLATION: translation <= wr_data[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    intr.cx  = principal[15:0];
    intr.cy  = principal[31:16];
    intr.ifx = inv_fx;
    intr.ify = inv_fy;
    intr.ids = inv_depth;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pose.r[i][j] = rot_row[i][18*j +: 18];
      end
      pose.t[i] = translation[21*i +: 21];
    end
  end

  always_comb begin
    pix_m           = request;
    pix_m.pixel_col = request.pixel_col & COORD_MASK;
    pix_m.pixel_row = request.pixel_row & COORD_MASK;
    pix_m.depth_raw = request.depth_raw & DEPTH_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy && (pix_m.depth_raw != '0);
    end
  end

  always_ff @(posedge clk) begin
    s0_pix <= pix_m;
  end

  dpw_backproject u_backproject (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .pix      (s0_pix),
    .intr     (intr),
    .cam      (cam)
  );

  dpw_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .cam       (cam),
    .pose      (pose),
    .out_valid (done),
    .point     (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/dpw_checker.sv @@
// dpw_checker: port-level assertions for depth_pixel_to_world_point_unit
// bound to the top level below; uses dpw_pkg
`default_nettype none

module dpw_checker #(
  parameter int DEPTH_BITS = 16
) (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            start,
  input wire logic            busy,
  input wire dpw_pkg::pixel_t request,
  input wire logic            done,
  input wire dpw_pkg::point_t result
);

  localparam int DEPTH_KEEP = (DEPTH_BITS < dpw_pkg::DEP_W) ? DEPTH_BITS : dpw_pkg::DEP_W;
  localparam logic [dpw_pkg::DEP_W-1:0] DEPTH_MASK =
    dpw_pkg::DEP_W'((64'd1 << DEPTH_KEEP) - 64'd1);

  logic take_nz;
  logic take_zero;

  assign take_nz   = start && !busy && ((request.depth_raw & DEPTH_MASK) != '0);
  assign take_zero = start && !busy && ((request.depth_raw & DEPTH_MASK) == '0);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take_nz |-> ##(dpw_pkg::LATENCY) done)
    else $error("request with depth gave no result");

  a_zero_silent: assert property (@(posedge clk) disable iff (rst)
    take_zero |-> ##(dpw_pkg::LATENCY) !done)
    else $error("request with zero depth gave a result");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take_nz, dpw_pkg::LATENCY))
    else $error("result without a matching request");

  a_color_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_blue == $past(request.blue, dpw_pkg::LATENCY)) &&
             (result.out_green == $past(request.green, dpw_pkg::LATENCY)) &&
             (result.out_red == $past(request.red, dpw_pkg::LATENCY)))
    else $error("color bytes changed on the way");

endmodule

bind depth_pixel_to_world_point_unit dpw_checker #(.DEPTH_BITS(DEPTH_BITS)) u_dpw_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for depth_pixel_to_world_point_unit
// directed table plus random pixel requests under several pose settings, checked by a predictor
// depends on dpw_pkg and the depth_pixel_to_world_point_unit rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;
  localparam int REG_COUNT = 8;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int MAX_GAP = 24;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [dpw_pkg::COL_W-1:0] COORD_MASK =
    dpw_pkg::COL_W'((32'd1 << COORD_BITS) - 1);
  localparam logic [dpw_pkg::DEP_W-1:0] DEPTH_MASK =
    dpw_pkg::DEP_W'((32'd1 << DEPTH_BITS) - 1);
  localparam int REG_WIDTH [REG_COUNT] = '{32, 24, 24, 24, 54, 54, 54, 63};

  typedef enum int {POSE_TYPICAL, POSE_WILD, POSE_MAX, POSE_MIN} pose_style_t;

  localparam pose_style_t PHASE_POSE [PHASES] = '{POSE_TYPICAL, POSE_WILD, POSE_MAX,
    POSE_TYPICAL, POSE_MIN, POSE_WILD, POSE_TYPICAL, POSE_TYPICAL};
  localparam int PHASE_IDLE_PCT [PHASES] = '{0, 71, 9, 71, 0, 9, 71, 9};

  typedef struct packed {
    logic            fixed;
    logic            yields;
    dpw_pkg::point_t point;
  } pixel_note_t;

  typedef struct packed {
    logic                       is_write;
    logic [dpw_pkg::IDX_W-1:0]  idx;
    logic [dpw_pkg::DATA_W-1:0] data;
    dpw_pkg::pixel_t            px;
    logic                       fixed;
    logic                       yields;
    dpw_pkg::point_t            point;
  } directed_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  dpw_pkg::pixel_t            request = '0;
  logic                       wr_en = 1'b0;
  logic [dpw_pkg::IDX_W-1:0]  wr_index = '0;
  logic [dpw_pkg::DATA_W-1:0] wr_data = '0;
  logic                       busy;
  logic                       done;
  dpw_pkg::point_t            result;

  logic [dpw_pkg::DATA_W-1:0] pose_regs [REG_COUNT];
  dpw_pkg::point_t            expected_points [$];
  pixel_note_t                pixel_notes [$];
  directed_row_t              directed_rows [$];
  int                         fail_count = 0;
  int                         cycle_count = 0;

  depth_pixel_to_world_point_unit #(
    .COORD_BITS(COORD_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [dpw_pkg::DATA_W-1:0] width_mask(int idx);
    logic [63:0] m;
    m = (64'd1 << REG_WIDTH[idx]) - 64'd1;
    return m[dpw_pkg::DATA_W-1:0];
  endfunction

  function automatic logic [dpw_pkg::DATA_W-1:0] pack_rot(logic [dpw_pkg::ROT_W-1:0] a,
                                                          logic [dpw_pkg::ROT_W-1:0] b,
                                                          logic [dpw_pkg::ROT_W-1:0] c);
    return {9'b0, c, b, a};
  endfunction

  function automatic logic [dpw_pkg::DATA_W-1:0] pack_trn(logic [dpw_pkg::TRN_W-1:0] a,
                                                          logic [dpw_pkg::TRN_W-1:0] b,
                                                          logic [dpw_pkg::TRN_W-1:0] c);
    return {c, b, a};
  endfunction

  function automatic dpw_pkg::point_t project_pixel(dpw_pkg::pixel_t px);
    dpw_pkg::point_t pt;
    longint col, row, depth, cx, cy, z, ax, ay, w;
    longint cam [3];
    logic [dpw_pkg::OUT_W-1:0] coord [3];
    int i, j;
    col = longint'(px.pixel_col & COORD_MASK);
    row = longint'(px.pixel_row & COORD_MASK);
    depth = longint'(px.depth_raw & DEPTH_MASK);
    cx = longint'(pose_regs[dpw_pkg::REG_PRINCIPAL][15:0]);
    cy = longint'(pose_regs[dpw_pkg::REG_PRINCIPAL][31:16]);
    z = (depth * longint'(pose_regs[dpw_pkg::REG_INV_DEPTH][dpw_pkg::FRAC_W-1:0]) + 128) >>> 8;
    ax = ((col * 16 - cx) * longint'(pose_regs[dpw_pkg::REG_INV_FX][dpw_pkg::FRAC_W-1:0])
          + 2048) >>> 12;
    ay = ((row * 16 - cy) * longint'(pose_regs[dpw_pkg::REG_INV_FY][dpw_pkg::FRAC_W-1:0])
          + 2048) >>> 12;
    cam[0] = (ax * z + 32768) >>> 16;
    cam[1] = (ay * z + 32768) >>> 16;
    cam[2] = z;
    for (i = 0; i < 3; i++) begin
      w = longint'($signed(pose_regs[dpw_pkg::REG_TRANSLATION][dpw_pkg::TRN_W*i +:
                                                                dpw_pkg::TRN_W])) <<< 22;
      for (j = 0; j < 3; j++) begin
        w += longint'($signed(pose_regs[dpw_pkg::REG_ROT_0 + i][dpw_pkg::ROT_W*j +:
                                                                dpw_pkg::ROT_W])) * cam[j];
      end
      w = (w + (longint'(1) <<< 19)) >>> 20;
      if (w > dpw_pkg::SAT_MAX) begin
        w = dpw_pkg::SAT_MAX;
      end else if (w < dpw_pkg::SAT_MIN) begin
        w = dpw_pkg::SAT_MIN;
      end
      coord[i] = w[dpw_pkg::OUT_W-1:0];
    end
    pt.world_x = coord[0];
    pt.world_y = coord[1];
    pt.world_z = coord[2];
    pt.out_blue = px.blue;
    pt.out_green = px.green;
    pt.out_red = px.red;
    return pt;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_ports
    dpw_pkg::point_t want;
    pixel_note_t note;
    if (rst) begin
      pose_regs[dpw_pkg::REG_PRINCIPAL] = dpw_pkg::DATA_W'(dpw_pkg::RST_PRINCIPAL);
      pose_regs[dpw_pkg::REG_INV_FX] = dpw_pkg::DATA_W'(dpw_pkg::RST_INV_FX);
      pose_regs[dpw_pkg::REG_INV_FY] = dpw_pkg::DATA_W'(dpw_pkg::RST_INV_FY);
      pose_regs[dpw_pkg::REG_INV_DEPTH] = dpw_pkg::DATA_W'(dpw_pkg::RST_INV_DEPTH);
      pose_regs[dpw_pkg::REG_ROT_0] = dpw_pkg::DATA_W'(dpw_pkg::RST_ROT_0);
      pose_regs[dpw_pkg::REG_ROT_1] = dpw_pkg::DATA_W'(dpw_pkg::RST_ROT_1);
      pose_regs[dpw_pkg::REG_ROT_2] = dpw_pkg::DATA_W'(dpw_pkg::RST_ROT_2);
      pose_regs[dpw_pkg::REG_TRANSLATION] = dpw_pkg::DATA_W'(dpw_pkg::RST_TRANSLATION);
    end else begin
      if (done) begin
        if (expected_points.size() == 0) begin
          $error("world point with no request waiting: x %0d y %0d z %0d",
                 result.world_x, result.world_y, result.world_z);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("world_x", int'(want.world_x), int'(result.world_x));
          check_field("world_y", int'(want.world_y), int'(result.world_y));
          check_field("world_z", int'(want.world_z), int'(result.world_z));
          check_field("out_blue", int'(want.out_blue), int'(result.out_blue));
          check_field("out_green", int'(want.out_green), int'(result.out_green));
          check_field("out_red", int'(want.out_red), int'(result.out_red));
        end
      end
      if (start && !busy && pixel_notes.size() != 0) begin
        note = pixel_notes.pop_front();
        if (note.fixed) begin
          if (note.yields) begin
            expected_points.insert(expected_points.size(), note.point);
          end
        end else if ((request.depth_raw & DEPTH_MASK) != '0) begin
          expected_points.insert(expected_points.size(), project_pixel(request));
        end
      end
      if (wr_en && wr_index < REG_COUNT) begin
        pose_regs[wr_index] = wr_data & width_mask(wr_index);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("depth_pixel_to_world_point_unit verification failed");
    $finish;
  end

  task automatic send_pixel(dpw_pkg::pixel_t px, logic fixed, logic yields,
                            dpw_pkg::point_t pt, int gap);
    pixel_note_t note;
    note.fixed = fixed;
    note.yields = yields;
    note.point = pt;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    pixel_notes.insert(pixel_notes.size(), note);
    start <= 1'b1;
    request <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (dpw_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [dpw_pkg::IDX_W-1:0] idx, logic [dpw_pkg::DATA_W-1:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [dpw_pkg::ROT_W-1:0] typical_gain();
    return dpw_pkg::ROT_W'($urandom_range(0, 131072)) - dpw_pkg::ROT_W'(65536);
  endfunction

  task automatic program_pose(pose_style_t style);
    logic [dpw_pkg::DATA_W-1:0] principal, ifx, ify, ids, rot0, rot1, rot2, trn;
    case (style)
      POSE_TYPICAL: begin
        principal = dpw_pkg::DATA_W'({16'($urandom), 16'($urandom)});
        ifx = dpw_pkg::DATA_W'($urandom_range(4096, 65536));
        ify = dpw_pkg::DATA_W'($urandom_range(4096, 65536));
        ids = dpw_pkg::DATA_W'($urandom_range(256, 65536));
        rot0 = pack_rot(typical_gain(), typical_gain(), typical_gain());
        rot1 = pack_rot(typical_gain(), typical_gain(), typical_gain());
        rot2 = pack_rot(typical_gain(), typical_gain(), typical_gain());
        trn = pack_trn(dpw_pkg::TRN_W'($urandom), dpw_pkg::TRN_W'($urandom),
                       dpw_pkg::TRN_W'($urandom));
      end
      POSE_WILD: begin
        principal = dpw_pkg::DATA_W'({$urandom, $urandom});
        ifx = dpw_pkg::DATA_W'({$urandom, $urandom});
        ify = dpw_pkg::DATA_W'({$urandom, $urandom});
        ids = dpw_pkg::DATA_W'({$urandom, $urandom});
        rot0 = dpw_pkg::DATA_W'({$urandom, $urandom});
        rot1 = dpw_pkg::DATA_W'({$urandom, $urandom});
        rot2 = dpw_pkg::DATA_W'({$urandom, $urandom});
        trn = dpw_pkg::DATA_W'({$urandom, $urandom});
      end
      POSE_MAX: begin
        principal = '1;
        ifx = '1;
        ify = '1;
        ids = '1;
        rot0 = pack_rot(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        rot1 = pack_rot(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        rot2 = pack_rot(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        trn = pack_trn(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF);
      end
      default: begin
        principal = '0;
        ifx = '0;
        ify = '0;
        ids = dpw_pkg::DATA_W'(1);
        rot0 = pack_rot(18'h20000, 18'h20000, 18'h20000);
        rot1 = pack_rot(18'h20000, 18'h20000, 18'h20000);
        rot2 = pack_rot(18'h20000, 18'h20000, 18'h20000);
        trn = pack_trn(21'h100000, 21'h100000, 21'h100000);
      end
    endcase
    write_reg(dpw_pkg::REG_PRINCIPAL, principal);
    write_reg(dpw_pkg::REG_INV_FX, ifx);
    write_reg(dpw_pkg::REG_INV_FY, ify);
    write_reg(dpw_pkg::IDX_W'($urandom_range(REG_COUNT, 15)),
              dpw_pkg::DATA_W'({$urandom, $urandom}));
    write_reg(dpw_pkg::REG_INV_DEPTH, ids);
    write_reg(dpw_pkg::REG_ROT_0, rot0);
    write_reg(dpw_pkg::REG_ROT_1, rot1);
    write_reg(dpw_pkg::REG_ROT_2, rot2);
    write_reg(dpw_pkg::REG_TRANSLATION, trn);
  endtask

  function automatic dpw_pkg::pixel_t random_pixel();
    dpw_pkg::pixel_t px;
    int pick;
    pick = $urandom_range(99);
    px.pixel_col = dpw_pkg::COL_W'($urandom);
    px.pixel_row = dpw_pkg::COL_W'($urandom);
    if (pick < 10) begin
      px.depth_raw = '0;
    end else if (pick < 30) begin
      px.depth_raw = dpw_pkg::DEP_W'($urandom_range(1, 255));
    end else begin
      px.depth_raw = dpw_pkg::DEP_W'($urandom_range(1, 65535));
    end
    px.blue = dpw_pkg::CLR_W'($urandom);
    px.green = dpw_pkg::CLR_W'($urandom);
    px.red = dpw_pkg::CLR_W'($urandom);
    return px;
  endfunction

  function automatic void add_write(logic [dpw_pkg::IDX_W-1:0] idx,
                                    logic [dpw_pkg::DATA_W-1:0] data);
    directed_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_pixel(int col, int row, int depth, logic [23:0] bgr,
                                    logic fixed = 1'b0, logic yields = 1'b0,
                                    int x = 0, int y = 0, int z = 0);
    directed_row_t r;
    r = '0;
    r.px.pixel_col = dpw_pkg::COL_W'(col);
    r.px.pixel_row = dpw_pkg::COL_W'(row);
    r.px.depth_raw = dpw_pkg::DEP_W'(depth);
    r.px.blue = bgr[23:16];
    r.px.green = bgr[15:8];
    r.px.red = bgr[7:0];
    r.fixed = fixed;
    r.yields = yields;
    r.point.world_x = dpw_pkg::OUT_W'(x);
    r.point.world_y = dpw_pkg::OUT_W'(y);
    r.point.world_z = dpw_pkg::OUT_W'(z);
    r.point.out_blue = bgr[23:16];
    r.point.out_green = bgr[15:8];
    r.point.out_red = bgr[7:0];
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  initial begin
    logic pixels_sent;
    int phase, n, gap, burst;
    pixels_sent = 1'b0;
    burst = 0;

    // reset pose
    add_pixel(0, 0, 1, 24'h00FF00);
    add_pixel(4095, 4095, 65535, 24'hFFFFFF);
    add_pixel(325, 253, 1000, 24'h123456);
    add_pixel(4095, 0, 0, 24'hFFFFFF, 1'b1, 1'b0);
    // depth only, one metre per 256 raw units
    add_write(dpw_pkg::REG_PRINCIPAL, '0);
    add_write(dpw_pkg::REG_INV_FX, '0);
    add_write(dpw_pkg::REG_INV_FY, '0);
    add_write(dpw_pkg::REG_INV_DEPTH, dpw_pkg::DATA_W'(65536));
    add_pixel(0, 0, 1, 24'h0000FF, 1'b1, 1'b1, 0, 0, 16);
    add_pixel(4095, 4095, 65535, 24'hFF00FF, 1'b1, 1'b1, 0, 0, 1048560);
    add_pixel(100, 200, 256, 24'hA5A5A5, 1'b1, 1'b1, 0, 0, 4096);
    add_pixel(2048, 2048, 0, 24'h000000, 1'b1, 1'b0);
    add_write(dpw_pkg::REG_TRANSLATION, pack_trn(21'h0FFFFF, 21'h100000, 21'h0));
    add_pixel(1, 2, 256, 24'h5A5A5A, 1'b1, 1'b1, 4194300, -4194304, 4096);
    // saturation both ways
    add_write(dpw_pkg::REG_INV_DEPTH, dpw_pkg::DATA_W'(24'hFFFFFF));
    add_pixel(4095, 4095, 65535, 24'h010203, 1'b1, 1'b1, 4194300, -4194304, 8388607);
    add_write(dpw_pkg::REG_ROT_2, pack_rot(18'h0, 18'h0, 18'h30000));
    add_pixel(4095, 4095, 65535, 24'h030201, 1'b1, 1'b1, 4194300, -4194304, -8388608);
    // writes past the register list change nothing
    add_write(dpw_pkg::IDX_W'(REG_COUNT), '1);
    add_write('1, '1);
    add_pixel(0, 0, 65535, 24'hC3C3C3, 1'b1, 1'b1, 4194300, -4194304, -8388608);
    add_write(dpw_pkg::REG_PRINCIPAL, '1);
    add_write(dpw_pkg::REG_INV_FX, '1);
    add_write(dpw_pkg::REG_INV_FY, '1);
    add_write(dpw_pkg::REG_INV_DEPTH, '1);
    add_write(dpw_pkg::REG_ROT_0, pack_rot(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    add_write(dpw_pkg::REG_ROT_1, pack_rot(18'h20000, 18'h20000, 18'h20000));
    add_write(dpw_pkg::REG_ROT_2, pack_rot(18'h1FFFF, 18'h20000, 18'h0));
    add_write(dpw_pkg::REG_TRANSLATION, pack_trn(21'h0FFFFF, 21'h100000, 21'h0FFFFF));
    add_pixel(0, 0, 65535, 24'h808080);
    add_pixel(4095, 4095, 65535, 24'h7F7F7F);
    add_pixel(0, 4095, 1, 24'h00FFFF);
    add_pixel(4095, 0, 2, 24'hFFFF00);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_write) begin
        if (pixels_sent) begin
          wait_idle();
          pixels_sent = 1'b0;
        end
        write_reg(directed_rows[k].idx, directed_rows[k].data);
      end else begin
        send_pixel(directed_rows[k].px, directed_rows[k].fixed, directed_rows[k].yields,
                   directed_rows[k].point, 0);
        pixels_sent = 1'b1;
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      program_pose(PHASE_POSE[phase]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst == 0 && $urandom_range(0, 31) == 0) begin
          burst = $urandom_range(8, 40);
        end
        gap = 0;
        if (burst > 0) begin
          burst--;
        end else begin
          while (gap < MAX_GAP && $urandom_range(99) < PHASE_IDLE_PCT[phase]) gap++;
        end
        send_pixel(random_pixel(), 1'b0, 1'b0, '0, gap);
      end
    end

    wait_idle();
    if (expected_points.size() != 0) begin
      $error("%0d world points never arrived", expected_points.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("depth_pixel_to_world_point_unit verification clean");
    end else begin
      $display("depth_pixel_to_world_point_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dpw_pkg.sv
rtl/core/dpw_backproject.sv
rtl/core/dpw_transform.sv
rtl/core/depth_pixel_to_world_point_unit.sv
rtl/core/dpw_checker.sv
verif/tb_top.sv
